// ===== rtl/core/conv1d_multichannel_padded_macros.svh =====
// Assertion macros shared by the convolution engine RTL.
`ifndef CONV1D_MULTICHANNEL_PADDED_MACROS_SVH
`define CONV1D_MULTICHANNEL_PADDED_MACROS_SVH

// Antecedent true in a cycle implies the consequent in the same cycle.
`define C1D_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c1d assertion failed");

// Antecedent true in a cycle implies the consequent in the next cycle.
`define C1D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c1d assertion failed");

`endif

// ===== rtl/core/c1d_pkg.sv =====
// Types and constants of the multichannel 1D convolution engine.
package c1d_pkg;

  localparam int XW  = 19;  // signed sampled position
  localparam int DVW = 18;  // divider dividend and quotient
  localparam int DSW = 10;  // divider divisor and remainder

  localparam logic [1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [1:0] REQ_WEIGHT  = 2'd1;
  localparam logic [1:0] REQ_BIAS    = 2'd2;
  localparam logic [1:0] REQ_COMPUTE = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BADCFG = 2'd1;
  localparam logic [1:0] STAT_RANGE  = 2'd2;

  localparam logic [1:0] PM_ZERO      = 2'd0;
  localparam logic [1:0] PM_REPLICATE = 2'd1;
  localparam logic [1:0] PM_REFLECT   = 2'd2;
  localparam logic [1:0] PM_CIRCULAR  = 2'd3;

  localparam logic [3:0] CFG_IN_CH    = 4'd0;
  localparam logic [3:0] CFG_OUT_CH   = 4'd1;
  localparam logic [3:0] CFG_IN_LEN   = 4'd2;
  localparam logic [3:0] CFG_KERN_LEN = 4'd3;
  localparam logic [3:0] CFG_PAD      = 4'd4;
  localparam logic [3:0] CFG_STRIDE   = 4'd5;
  localparam logic [3:0] CFG_DILATION = 4'd6;
  localparam logic [3:0] CFG_MODE     = 4'd7;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         out_chan;
    logic [3:0]         in_chan;
    logic [7:0]         position;
    logic signed [15:0] data_value;
    logic signed [31:0] bias_value;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] result_value;
    logic [1:0]         status;
    logic [9:0]         out_length;
  } out_item_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_LEN   = 8'b0000_0010,
    ST_DLEN  = 8'b0000_0100,
    ST_DX    = 8'b0000_1000,
    ST_DD    = 8'b0001_0000,
    ST_ACC   = 8'b0010_0000,
    ST_DRAIN = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic           start;
    logic [DVW-1:0] dividend;
    logic [DSW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [DVW-1:0] quo;
    logic [DSW-1:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/core/c1d_ram.sv =====
// Generic simple dual-port RAM with registered read.
module c1d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/c1d_div.sv =====
// Restoring divider, one quotient bit per cycle.
module c1d_div
  import c1d_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(DVW + 1);

  logic [DVW-1:0] quo_r, quo_nxt;
  logic [DSW-1:0] rem_r, rem_nxt;
  logic [DSW-1:0] dsr_r, dsr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [DSW:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[DVW-1]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = CW'(DVW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DSW'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[DVW-2:0], 1'b1};
      end else begin
        rem_nxt = DSW'(trial);
        quo_nxt = {quo_r[DVW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/core/conv1d_multichannel_padded.sv =====
// Top level of the multichannel 1D convolution engine.
//
// Input channel: in_valid/in_stall carrying one in_item_t per transaction.
// Load transactions (sample, weight, bias) write their store in the cycle they
// are taken and give no result; the block can take the next item right after.
// A compute transaction produces one out_item_t on out_valid/out_stall.
// A compute first runs three passes of the shared divider (output length,
// start phase of the sampled position, dilation phase) and then one
// multiply-accumulate per cycle through the sample and weight RAM read ports.
// A setting that fails the configuration check answers without a divider
// pass, a position past the end after the first pass.
// The block takes no new item while a compute is in flight (in_stall high).
// The result sits in an output register; if the receiver stalls, the finished
// result waits there while the block may still take further items, and a
// following compute waits at its end for the register to empty.
// Configuration writes on cfg_valid/cfg_ready are always ready and must only
// be issued while the block is idle. Synchronous reset restores register
// defaults and empties the pipeline; the stores keep their contents and must
// be loaded before they are used.
`include "conv1d_multichannel_padded_macros.svh"

module conv1d_multichannel_padded
  import c1d_pkg::*;
#(
  parameter int MAX_IN_CH    = 16,
  parameter int MAX_OUT_CH   = 16,
  parameter int MAX_IN_LEN   = 256,
  parameter int MAX_KERN_LEN = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SDEPTH = MAX_IN_CH * MAX_IN_LEN;
  localparam int WDEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_KERN_LEN;
  localparam int SAW = SDEPTH > 1 ? $clog2(SDEPTH) : 1;
  localparam int WAW = WDEPTH > 1 ? $clog2(WDEPTH) : 1;
  localparam int BAW = MAX_OUT_CH > 1 ? $clog2(MAX_OUT_CH) : 1;
  localparam logic signed [40:0] ACC_MAX = 41'sh0_7F_FFFF_FFFF;
  localparam logic signed [40:0] ACC_MIN = -41'sh0_80_0000_0000;

  // Configuration registers.
  logic [4:0]        in_ch_r, out_ch_r, klen_r;
  logic [8:0]        in_len_r, stride_r;
  logic signed [9:0] pad_r;
  logic [7:0]        dil_r;
  logic [2:0]        mode_r;

  state_t            state_r, state_nxt;
  in_item_t          item_r;
  logic [1:0]        status_r, status_nxt;
  logic [9:0]        len_r, len_nxt;
  logic signed [XW-1:0] x0_r, x0_nxt, x_r, x_nxt;
  logic [DSW-1:0]    per_r, per_nxt, m0_r, m0_nxt, m_r, m_nxt, dm_r, dm_nxt;
  logic [4:0]        i_r, i_nxt, t_r, t_nxt;
  logic signed [39:0] acc_r, acc_nxt;
  logic signed [31:0] p_r;
  logic              rd_v_r, rd_v_nxt, p_v_r;
  out_item_t         out_r;
  logic              out_valid_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [15:0] smp_q, wgt_q;
  logic [31:0] bias_q;

  logic in_acc;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ch_r  <= 5'd1;
      out_ch_r <= 5'd1;
      in_len_r <= 9'd1;
      klen_r   <= 5'd1;
      pad_r    <= '0;
      stride_r <= 9'd1;
      dil_r    <= 8'd1;
      mode_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IN_CH:    in_ch_r  <= cfg_data[4:0];
        CFG_OUT_CH:   out_ch_r <= cfg_data[4:0];
        CFG_IN_LEN:   in_len_r <= cfg_data[8:0];
        CFG_KERN_LEN: klen_r   <= cfg_data[4:0];
        CFG_PAD:      pad_r    <= $signed(cfg_data[9:0]);
        CFG_STRIDE:   stride_r <= cfg_data[8:0];
        CFG_DILATION: dil_r    <= cfg_data[7:0];
        CFG_MODE:     mode_r   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic [1:0] pm;
  assign pm = mode_r[2:1];

  // Store writes happen as load transactions are taken.
  logic           s_we, w_we, b_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [BAW-1:0] b_waddr;
  logic           oc_ok;

  assign s_we = in_acc && (in_data.req_type == REQ_SAMPLE) &&
                (32'(in_data.in_chan) < MAX_IN_CH) && (32'(in_data.position) < MAX_IN_LEN);
  assign w_we = in_acc && (in_data.req_type == REQ_WEIGHT) &&
                (32'(in_data.out_chan) < MAX_OUT_CH) && (32'(in_data.in_chan) < MAX_IN_CH) &&
                (32'(in_data.position) < MAX_KERN_LEN);
  assign b_we = in_acc && (in_data.req_type == REQ_BIAS) &&
                (32'(in_data.out_chan) < MAX_OUT_CH);
  assign s_waddr = SAW'(32'(in_data.in_chan) * MAX_IN_LEN + 32'(in_data.position));
  assign w_waddr = WAW'((32'(in_data.out_chan) * MAX_IN_CH + 32'(in_data.in_chan))
                        * MAX_KERN_LEN + 32'(in_data.position));
  assign b_waddr = BAW'(in_data.out_chan);
  assign oc_ok   = (32'(item_r.out_chan) < MAX_OUT_CH);

  c1d_ram #(.WIDTH(16), .DEPTH(SDEPTH)) u_sample_ram (
    .clk(clk), .we(s_we), .wr_addr(s_waddr), .wr_data(in_data.data_value),
    .rd_addr(s_raddr), .rd_data(smp_q)
  );
  c1d_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_weight_ram (
    .clk(clk), .we(w_we), .wr_addr(w_waddr), .wr_data(in_data.data_value),
    .rd_addr(w_raddr), .rd_data(wgt_q)
  );
  c1d_ram #(.WIDTH(32), .DEPTH(MAX_OUT_CH)) u_bias_ram (
    .clk(clk), .we(b_we), .wr_addr(b_waddr), .wr_data(in_data.bias_value),
    .rd_addr(BAW'(item_r.out_chan)), .rd_data(bias_q)
  );

  c1d_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // Configuration check and padded spans.
  logic signed [15:0] li_s, pad_s, ti_s, tk_s, span_s;
  logic [15:0]        tk_u;
  logic               cfg_ok;

  always_comb begin
    li_s   = $signed(16'(in_len_r));
    pad_s  = 16'(pad_r);
    ti_s   = li_s + pad_s + pad_s;
    tk_u   = 16'(dil_r) * 16'(klen_r - 5'd1) + 16'd1;
    tk_s   = $signed(tk_u);
    span_s = ti_s - tk_s;
    cfg_ok = (in_ch_r != 5'd0) && (32'(in_ch_r) <= MAX_IN_CH) &&
             (out_ch_r != 5'd0) && (32'(out_ch_r) <= MAX_OUT_CH) &&
             (in_len_r != 9'd0) && (32'(in_len_r) <= MAX_IN_LEN) &&
             (klen_r != 5'd0) && (32'(klen_r) <= MAX_KERN_LEN) &&
             (stride_r != 9'd0) && (dil_r != 8'd0) &&
             (pad_s + li_s > 16'sd0) &&
             !((pm != PM_ZERO) && (pad_s > li_s)) &&
             !((pm == PM_REFLECT) && (pad_s >= li_s)) &&
             (ti_s >= tk_s);
  end

  // Per-tap resolution of the sampled position.
  logic          x_neg, x_hi, use_tap;
  logic [8:0]    r_idx;
  logic [DSW:0]  m_sum;
  logic [11:0]   lo_w;
  logic [XW-1:0] x0_mag;

  always_comb begin
    x_neg   = x_r[XW-1];
    x_hi    = (x_r >= $signed(XW'(in_len_r)));
    use_tap = oc_ok;
    r_idx   = x_r[8:0];
    case (pm)
      PM_ZERO: begin
        use_tap = oc_ok && !x_neg && !x_hi;
      end
      PM_REPLICATE: begin
        if (x_neg) begin
          r_idx = '0;
        end else if (x_hi) begin
          r_idx = in_len_r - 9'd1;
        end
      end
      PM_CIRCULAR: begin
        r_idx = m_r[8:0];
      end
      default: begin
        // Reflect: fold the residue of the mirrored period back into range.
        r_idx = (m_r >= DSW'(in_len_r)) ? 9'(per_r - m_r) : m_r[8:0];
      end
    endcase
    m_sum  = {1'b0, m_r} + {1'b0, dm_r};
    lo_w   = 12'(div_rsp.quo) + 12'd1 + 12'(mode_r[0] && (div_rsp.rem != '0));
    x0_mag = x0_r[XW-1] ? XW'(-x0_r) : XW'(x0_r);
  end

  assign s_raddr = SAW'(32'(i_r) * MAX_IN_LEN + 32'(r_idx));
  assign w_raddr = WAW'((32'(item_r.out_chan) * MAX_IN_CH + 32'(i_r)) * MAX_KERN_LEN
                        + 32'(t_r));

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    len_nxt    = len_r;
    x0_nxt     = x0_r;
    x_nxt      = x_r;
    per_nxt    = per_r;
    m0_nxt     = m0_r;
    m_nxt      = m_r;
    dm_nxt     = dm_r;
    i_nxt      = i_r;
    t_nxt      = t_r;
    acc_nxt    = acc_r;
    rd_v_nxt   = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DVW'(span_s);
    div_req.divisor  = DSW'(stride_r);
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.req_type == REQ_COMPUTE)) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        x0_nxt  = $signed(XW'(item_r.position) * XW'(stride_r)) - XW'(pad_r);
        per_nxt = (pm == PM_REFLECT) ?
                  ((in_len_r == 9'd1) ? DSW'(1) : DSW'({in_len_r - 9'd1, 1'b0})) :
                  DSW'(in_len_r);
        if (cfg_ok) begin
          div_req.start = 1'b1;
          state_nxt = ST_DLEN;
        end else begin
          status_nxt = STAT_BADCFG;
          len_nxt    = '0;
          state_nxt  = ST_FIN;
        end
      end
      ST_DLEN: begin
        acc_nxt = oc_ok ? 40'($signed(bias_q)) : '0;
        div_req.dividend = DVW'(x0_mag);
        div_req.divisor  = per_r;
        if (div_rsp.done) begin
          len_nxt = 10'(lo_w);
          if (lo_w > 12'd1023) begin
            status_nxt = STAT_BADCFG;
            len_nxt    = '0;
            state_nxt  = ST_FIN;
          end else if (12'(item_r.position) >= lo_w) begin
            status_nxt = STAT_RANGE;
            state_nxt  = ST_FIN;
          end else begin
            status_nxt    = STAT_OK;
            div_req.start = 1'b1;
            state_nxt     = ST_DX;
          end
        end
      end
      ST_DX: begin
        div_req.dividend = DVW'(dil_r);
        div_req.divisor  = per_r;
        if (div_rsp.done) begin
          // A negative start position mirrors its residue into 0..per-1.
          m0_nxt = (x0_r[XW-1] && (div_rsp.rem != '0)) ? per_r - div_rsp.rem : div_rsp.rem;
          div_req.start = 1'b1;
          state_nxt = ST_DD;
        end
      end
      ST_DD: begin
        if (div_rsp.done) begin
          dm_nxt    = div_rsp.rem;
          x_nxt     = x0_r;
          m_nxt     = m0_r;
          i_nxt     = '0;
          t_nxt     = '0;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        rd_v_nxt = use_tap;
        if (t_r == klen_r - 5'd1) begin
          t_nxt = '0;
          x_nxt = x0_r;
          m_nxt = m0_r;
          i_nxt = i_r + 5'd1;
          if (i_r == in_ch_r - 5'd1) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          t_nxt = t_r + 5'd1;
          x_nxt = x_r + XW'(dil_r);
          m_nxt = (m_sum >= {1'b0, per_r}) ? DSW'(m_sum - {1'b0, per_r}) : DSW'(m_sum);
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !p_v_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // Multiply-accumulate tail: the sum saturates after every addition.
    if (p_v_r) begin
      if (41'(acc_r) + 41'(p_r) > ACC_MAX) begin
        acc_nxt = ACC_MAX[39:0];
      end else if (41'(acc_r) + 41'(p_r) < ACC_MIN) begin
        acc_nxt = ACC_MIN[39:0];
      end else begin
        acc_nxt = 40'(41'(acc_r) + 41'(p_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_v_r      <= 1'b0;
      p_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= rd_v_nxt;
      p_v_r   <= rd_v_r;
      if (state_r == ST_FIN && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      item_r <= in_data;
    end
    status_r <= status_nxt;
    len_r    <= len_nxt;
    x0_r     <= x0_nxt;
    x_r      <= x_nxt;
    per_r    <= per_nxt;
    m0_r     <= m0_nxt;
    m_r      <= m_nxt;
    dm_r     <= dm_nxt;
    i_r      <= i_nxt;
    t_r      <= t_nxt;
    acc_r    <= acc_nxt;
    p_r      <= 32'($signed(wgt_q) * $signed(smp_q));
    if (state_r == ST_FIN && (!out_valid_r || !out_stall)) begin
      out_r.result_value <= (status_r == STAT_OK) ? acc_r : '0;
      out_r.status       <= status_r;
      out_r.out_length   <= len_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `C1D_ASSERT_NEXT(a_compute_starts, in_acc && (in_data.req_type == REQ_COMPUTE), state_r == ST_LEN)
  `C1D_ASSERT_SAME(a_error_zero, out_valid_r && (out_r.status != STAT_OK), out_r.result_value == '0)
  `C1D_ASSERT_SAME(a_read_in_acc, rd_v_r, $past(state_r == ST_ACC))

endmodule

// ===== tb/tb_conv1d_multichannel_padded.sv =====
// Self-checking testbench for the multichannel 1D convolution engine.
module tb_conv1d_multichannel_padded;
  import c1d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NIC = 16;
  localparam int NOC = 16;
  localparam int NLEN = 256;
  localparam int NK = 16;
  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -64'sd549755813888;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  conv1d_multichannel_padded DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // Predictor copy of registers and stores.
  int unsigned n_in_ch, n_out_ch, len_in, len_k, stride, dil;
  int pad;
  logic [2:0] mode_r;
  logic signed [15:0] samples [NIC*NLEN];
  logic signed [15:0] weights [NOC*NIC*NK];
  logic signed [31:0] biases [NOC];

  in_item_t pending_items[$];
  out_item_t expected_outputs[$];
  int errors = 0;
  int n_results = 0;
  int n_items = 0;
  bit in_noise = 1'b1;
  bit out_noise = 1'b1;
  int hold_cycles = 0;

  function automatic int conv_length();
    longint ti, tk, lo;
    logic [1:0] pm;
    pm = mode_r[2:1];
    if (n_in_ch < 1 || n_in_ch > NIC || n_out_ch < 1 || n_out_ch > NOC) return 0;
    if (len_in < 1 || len_in > NLEN || len_k < 1 || len_k > NK) return 0;
    if (stride < 1 || dil < 1) return 0;
    if (pad <= -int'(len_in)) return 0;
    if (pm != PM_ZERO && pad > int'(len_in)) return 0;
    if (pm == PM_REFLECT && pad >= int'(len_in)) return 0;
    ti = longint'(len_in) + 2 * pad;
    tk = longint'(dil) * (len_k - 1) + 1;
    if (ti < tk) return 0;
    lo = 1 + (ti - tk) / stride + ((mode_r[0] && ((ti - tk) % stride) != 0) ? 1 : 0);
    if (lo > 1023) return 0;
    return int'(lo);
  endfunction

  function automatic longint wrap_mod(longint a, longint m);
    longint r;
    r = a % m;
    return r < 0 ? r + m : r;
  endfunction

  function automatic longint pad_index(longint x);
    longint li, per, m;
    li = len_in;
    if (x >= 0 && x < li) return x;
    case (mode_r[2:1])
      PM_ZERO: return -1;
      PM_REPLICATE: return x < 0 ? 0 : li - 1;
      PM_CIRCULAR: return wrap_mod(x, li);
      default: begin
        if (li == 1) return 0;
        per = 2 * (li - 1);
        m = wrap_mod(x, per);
        return m >= li ? per - m : m;
      end
    endcase
  endfunction

  // Applies one input transaction to the predictor; returns 1 if a result follows.
  function automatic bit predict_element(in_item_t it, output out_item_t res);
    int lo;
    longint acc, x, r;
    res = '0;
    case (it.req_type)
      REQ_SAMPLE: begin
        samples[it.in_chan*NLEN + it.position] = it.data_value;
        return 0;
      end
      REQ_WEIGHT: begin
        if (it.position < NK) weights[(it.out_chan*NIC + it.in_chan)*NK + it.position] = it.data_value;
        return 0;
      end
      REQ_BIAS: begin
        biases[it.out_chan] = it.bias_value;
        return 0;
      end
      default: begin
        lo = conv_length();
        res.out_length = lo[9:0];
        if (lo == 0) res.status = STAT_BADCFG;
        else if (int'(it.position) >= lo) res.status = STAT_RANGE;
        else begin
          acc = biases[it.out_chan];
          for (int i = 0; i < n_in_ch; i++)
            for (int t = 0; t < len_k; t++) begin
              x = longint'(it.position) * stride + longint'(t) * dil - pad;
              r = pad_index(x);
              if (r < 0) continue;
              acc += longint'(weights[(it.out_chan*NIC + i)*NK + t]) *
                     longint'(samples[i*NLEN + r]);
              if (acc > ACC_HI) acc = ACC_HI;
              if (acc < ACC_LO) acc = ACC_LO;
            end
          res.result_value = acc[39:0];
          res.status = STAT_OK;
        end
        return 1;
      end
    endcase
  endfunction

  // Driver: the predictor runs when a transaction is accepted.
  int in_gap = 0;
  always @(posedge clk) begin
    out_item_t res;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        n_items++;
        if (predict_element(in_data, res)) expected_outputs.push_back(res);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (in_noise && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall generation.
  int out_gap = 0;
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_outputs.size() == 0) begin
          $error("unexpected result %p", out_data);
          errors++;
        end else begin
          exp_r = expected_outputs.pop_front();
          if (out_data.result_value !== exp_r.result_value) begin
            $error("result_value expected %0d actual %0d", exp_r.result_value,
                   out_data.result_value);
            errors++;
          end
          if (out_data.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, out_data.status);
            errors++;
          end
          if (out_data.out_length !== exp_r.out_length) begin
            $error("out_length expected %0d actual %0d", exp_r.out_length,
                   out_data.out_length);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (out_noise && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  task automatic write_reg(input logic [3:0] idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IN_CH:    n_in_ch = value & 'h1f;
      CFG_OUT_CH:   n_out_ch = value & 'h1f;
      CFG_IN_LEN:   len_in = value & 'h1ff;
      CFG_KERN_LEN: len_k = value & 'h1f;
      CFG_PAD:      pad = int'(signed'(10'(value)));
      CFG_STRIDE:   stride = value & 'h1ff;
      CFG_DILATION: dil = value & 'hff;
      CFG_MODE:     mode_r = value[2:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_outputs.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic in_item_t make_item(logic [1:0] rt, int oc, int ic, int p,
                                         int dv, int bv);
    in_item_t it;
    it.req_type = rt;
    it.out_chan = oc[3:0];
    it.in_chan = ic[3:0];
    it.position = p[7:0];
    it.data_value = dv[15:0];
    it.bias_value = bv;
    return it;
  endfunction

  // Loads every sample, weight and bias that a setting can read.
  task automatic fill_stores(int nic, int noc, int nlen, int nk, bit extreme);
    for (int i = 0; i < nic; i++)
      for (int p = 0; p < nlen; p++)
        pending_items.push_back(make_item(REQ_SAMPLE, $urandom, i, p,
          extreme ? 16'h8000 : $urandom, $urandom));
    for (int o = 0; o < noc; o++) begin
      pending_items.push_back(make_item(REQ_BIAS, o, $urandom, $urandom, $urandom,
        extreme ? 32'h7fffffff : $urandom));
      for (int i = 0; i < nic; i++)
        for (int t = 0; t < nk; t++)
          pending_items.push_back(make_item(REQ_WEIGHT, o, i, t,
            extreme ? 16'h8000 : $urandom, $urandom));
    end
  endtask

  task automatic compute_batch(int count, int noc);
    int lo;
    lo = conv_length();
    for (int k = 0; k < count; k++)
      pending_items.push_back(make_item(REQ_COMPUTE, $urandom_range(0, noc - 1),
        $urandom, (lo > 0 && $urandom_range(0, 7) != 0) ?
        $urandom_range(0, (lo > 256 ? 256 : lo) - 1) : $urandom_range(0, 255),
        $urandom, $urandom));
  endtask

  task automatic set_all(int nic, int noc, int nlen, int nk, int pd, int st, int dl,
                         int md);
    write_reg(CFG_IN_CH, nic);
    write_reg(CFG_OUT_CH, noc);
    write_reg(CFG_IN_LEN, nlen);
    write_reg(CFG_KERN_LEN, nk);
    write_reg(CFG_PAD, pd);
    write_reg(CFG_STRIDE, st);
    write_reg(CFG_DILATION, dl);
    write_reg(CFG_MODE, md);
  endtask

  initial begin
    int nic, noc, nlen, nk, pd, st, dl, md;
    n_in_ch = 1; n_out_ch = 1; len_in = 1; len_k = 1;
    pad = 0; stride = 1; dil = 1; mode_r = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every entry the first setting reads is written with extremes.
    fill_stores(2, 2, 16, 4, 1'b1);
    wait_drained();
    set_all(2, 2, 16, 4, 7, 1, 1, 0);
    // Extreme products, a position past the end, and every pad and length mode.
    for (int m = 0; m < 8; m++) begin
      write_reg(CFG_MODE, m);
      pending_items.push_back(make_item(REQ_COMPUTE, 1, 0, 0, 0, 0));
      pending_items.push_back(make_item(REQ_COMPUTE, 0, 0, 255, 0, 0));
      pending_items.push_back(make_item(REQ_COMPUTE, 1, 0, 5, 0, 0));
      wait_drained();
    end
    // Invalid settings: reflect with pad >= length, zero stride, trim too far.
    set_all(1, 1, 16, 16, 16, 1, 1, 4);
    pending_items.push_back(make_item(REQ_COMPUTE, 0, 0, 0, 0, 0));
    wait_drained();
    set_all(0, 0, 16, 0, -16, 0, 0, 6);
    pending_items.push_back(make_item(REQ_COMPUTE, 0, 0, 0, 0, 0));
    wait_drained();
    set_all(1, 1, 1, 1, -255, 256, 255, 7);
    pending_items.push_back(make_item(REQ_COMPUTE, 0, 0, 0, 0, 0));
    wait_drained();
    // Widest output length: length 256, pad 256, zero mode; these taps all
    // land in the padding, so only the bias is read.
    set_all(1, 1, 256, 1, 256, 1, 1, 0);
    pending_items.push_back(make_item(REQ_COMPUTE, 0, 0, 255, 0, 0));
    pending_items.push_back(make_item(REQ_COMPUTE, 0, 0, 0, 0, 0));
    wait_drained();

    // Random phases: load small stores, then compute under a random setting.
    for (int ph = 0; ph < 7; ph++) begin
      nic = $urandom_range(1, 3);
      noc = $urandom_range(1, 2);
      nlen = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 12);
      nk = $urandom_range(1, 4);
      md = $urandom_range(0, 7);
      pd = $signed($urandom_range(0, nlen + 2)) - 2;
      st = $urandom_range(1, 4);
      dl = $urandom_range(1, 3);
      if (ph == 6) begin
        nic = 4; nk = 16; noc = 1; nlen = 8; pd = 1;
      end
      if (ph >= 5) begin
        in_noise = 1'b0;
        out_noise = 1'b0;
      end
      fill_stores(nic, noc, nlen, nk, 1'b0);
      // A broken load that the block must ignore.
      pending_items.push_back(make_item(REQ_WEIGHT, 0, 0, $urandom_range(16, 255), $urandom, 0));
      wait_drained();
      set_all(nic, noc, nlen, nk, pd, st, dl, md);
      if (ph == 2) hold_cycles = 3000;
      compute_batch(12, noc);
      wait_drained();
    end

    $display("tb: %0d transactions driven, %0d results checked across pad modes,",
             n_items, n_results);
    $display("tb: length modes, invalid settings, extreme data and stalls.");
    if (errors == 0 && expected_outputs.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
